### rtl/hash_set_membership_table_top_macros.svh
// Assertion macros used by the checker of the hash set membership table.
`ifndef HASH_SET_MEMBERSHIP_TABLE_TOP_MACROS_SVH
`define HASH_SET_MEMBERSHIP_TABLE_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HSMT_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define HSMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/hsmt_pkg.sv
// Package of the hash set membership table: command codes, widths, hash constants.
`default_nettype none

package hsmt_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned MUL_W = 22;

  // h = key * HASH_MUL + 78126498113, low 32 bits; the adder is the addend mod 2^32.
  localparam logic [MUL_W-1:0] HASH_MUL = 22'd2895701;
  localparam logic [KEY_W-1:0] HASH_ADD = 32'd817086785;

  typedef enum logic [CMD_W-1:0] {
    CmdInsert = 2'd0,
    CmdExists = 2'd1,
    CmdRemove = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

### rtl/hsmt_if.sv
// Valid/ready channel interfaces for commands in and results out.
`default_nettype none

interface hsmt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [hsmt_pkg::CMD_W-1:0]           command;
  logic signed [hsmt_pkg::KEY_W-1:0]    key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface hsmt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       rejected;
  logic [hsmt_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, output found, output rejected, output entry_count, input ready);
  modport sink   (input valid, input found, input rejected, input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/hash_set_membership_table_top.sv
// Top level of the hash set membership table: front end, queue and back end.
`default_nettype none

// Keeps a set of signed 32-bit keys in NUM_BUCKETS buckets of BUCKET_SLOTS
// slots each. Every transfer on cmd_i (insert, exists, remove; the unused
// code acts as exists) yields exactly one transfer on res_o with found (key
// was present before), rejected (insert dropped, bucket full) and the entry
// count after the operation. The bucket is |low32(key*2895701+78126498113)|
// mod NUM_BUCKETS; an insert takes the lowest free slot of its bucket.
// The back end handles one item at a time: a registered read of the bucket
// row, then compare across all slots and write back on the same row store;
// it takes no new item until the result of the last is committed, and a
// result that waits on res_o holds it. A cmd_i transfer loads the first of
// 6 hash pipeline stages (multiply, add, magnitude, reciprocal multiply,
// remainder, correction), then the item passes the 2-entry queue and the
// row update.
// The hash pipeline and queue keep taking commands while a result waits on
// res_o, until the queue backs up. After reset, a clearing pass zeroes the
// valid bits one bucket row per cycle: cmd_i.ready stays low until the
// pass is done.

module hash_set_membership_table_top #(
  parameter int unsigned NUM_BUCKETS  = 64,
  parameter int unsigned BUCKET_SLOTS = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  hsmt_in_if.sink     cmd_i,
  hsmt_out_if.source  res_o
);

  localparam int unsigned BktW = $clog2(NUM_BUCKETS);
  localparam int unsigned QW   = hsmt_pkg::CMD_W + hsmt_pkg::KEY_W + BktW;

  logic                       clr_done;
  // front end to queue
  logic                       f_valid, f_ready;
  logic [hsmt_pkg::CMD_W-1:0] f_cmd;
  logic [hsmt_pkg::KEY_W-1:0] f_key;
  logic [BktW-1:0]            f_bkt;
  // queue to back end
  logic                       b_valid, b_ready;
  logic [QW-1:0]              q_in, q_out;

  hsmt_front #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clr_done_i    (clr_done),
    .in_i          (cmd_i),
    .push_valid_o  (f_valid),
    .push_ready_i  (f_ready),
    .push_cmd_o    (f_cmd),
    .push_key_o    (f_key),
    .push_bucket_o (f_bkt)
  );

  assign q_in = {f_cmd, f_key, f_bkt};

  hsmt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  hsmt_back #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_SLOTS (BUCKET_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_done_o   (clr_done),
    .pop_valid_i  (b_valid),
    .pop_ready_o  (b_ready),
    .pop_cmd_i    (q_out[QW-1 -: hsmt_pkg::CMD_W]),
    .pop_key_i    (q_out[BktW +: hsmt_pkg::KEY_W]),
    .pop_bucket_i (q_out[BktW-1:0]),
    .out_o        (res_o)
  );

endmodule

`default_nettype wire

### rtl/hsmt_front.sv
// Front end: accepts commands and computes each key's bucket in a stallable pipeline.
`default_nettype none

module hsmt_front #(
  parameter int unsigned NUM_BUCKETS = 64,
  localparam int unsigned BktW = $clog2(NUM_BUCKETS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_done_i,
  hsmt_in_if.sink                    in_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output logic [hsmt_pkg::CMD_W-1:0] push_cmd_o,
  output logic [hsmt_pkg::KEY_W-1:0] push_key_o,
  output logic [BktW-1:0]            push_bucket_o
);

  // mul, add, abs, reciprocal mul, remainder, final correction
  localparam int unsigned Stages = 6;
  localparam int unsigned RemW   = $clog2(2 * NUM_BUCKETS);
  localparam logic [31:0] Recip  = 32'((64'd1 << 32) / NUM_BUCKETS);
  localparam logic [RemW-1:0] NbRem = RemW'(NUM_BUCKETS);

  logic                       advance;
  logic                       accept;
  logic [hsmt_pkg::KEY_W-1:0] key_u;
  logic [hsmt_pkg::KEY_W+hsmt_pkg::MUL_W-1:0] prod_full;
  logic [31:0]                mag_d;
  logic [63:0]                quo_full;
  logic [2*RemW-1:0]          qn_full;
  logic [RemW-1:0]            rem_d;
  logic [BktW-1:0]            bkt_d;

  logic [Stages-1:0]          v_q;
  logic [hsmt_pkg::CMD_W-1:0] cmd_q [Stages];
  logic [hsmt_pkg::KEY_W-1:0] key_q [Stages];
  logic [31:0]                prod_q, hash_q, mag_q, quo_q;
  logic [RemW-1:0]            mlo_q, rem_q;
  logic [BktW-1:0]            bkt_q;

  assign advance    = !v_q[Stages-1] || push_ready_i;
  assign in_i.ready = advance && clr_done_i;
  assign accept     = in_i.valid && in_i.ready;
  assign key_u      = $unsigned(in_i.key);

  always_comb begin
    prod_full = key_u * hsmt_pkg::HASH_MUL;
    // two's complement magnitude; the most negative hash maps to 2^31
    mag_d     = hash_q[31] ? (~hash_q + 32'd1) : hash_q;
    // quotient estimate is low by at most one, so the remainder stays below 2N
    quo_full  = mag_q * Recip;
    qn_full   = quo_q[RemW-1:0] * NbRem;
    rem_d     = mlo_q - qn_full[RemW-1:0];
    bkt_d     = (rem_q >= NbRem) ? BktW'(rem_q - NbRem) : BktW'(rem_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (advance) begin
      v_q <= {v_q[Stages-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_q[0] <= in_i.command;
      key_q[0] <= key_u;
      for (int i = 1; i < Stages; i++) begin
        cmd_q[i] <= cmd_q[i-1];
        key_q[i] <= key_q[i-1];
      end
      prod_q <= prod_full[31:0];
      hash_q <= prod_q + hsmt_pkg::HASH_ADD;
      mag_q  <= mag_d;
      quo_q  <= quo_full[63:32];
      mlo_q  <= mag_q[RemW-1:0];
      rem_q  <= rem_d;
      bkt_q  <= bkt_d;
    end
  end

  assign push_valid_o  = v_q[Stages-1];
  assign push_cmd_o    = cmd_q[Stages-1];
  assign push_key_o    = key_q[Stages-1];
  assign push_bucket_o = bkt_q;

endmodule

`default_nettype wire

### rtl/hsmt_queue.sv
// Two-entry queue between the hashing front end and the table back end.
`default_nettype none

module hsmt_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/hsmt_back.sv
// Back end: bucket row read, parallel slot compare, write back and result register.
`default_nettype none

module hsmt_back #(
  parameter int unsigned NUM_BUCKETS  = 64,
  parameter int unsigned BUCKET_SLOTS = 4,
  localparam int unsigned BktW = $clog2(NUM_BUCKETS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       clr_done_o,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  logic [hsmt_pkg::CMD_W-1:0] pop_cmd_i,
  input  logic [hsmt_pkg::KEY_W-1:0] pop_key_i,
  input  logic [BktW-1:0]            pop_bucket_i,
  hsmt_out_if.source                 out_o
);

  typedef enum logic [1:0] {StClear, StIdle, StExec} state_e;
  typedef logic [BUCKET_SLOTS-1:0][hsmt_pkg::KEY_W-1:0] row_t;
  typedef logic [BUCKET_SLOTS-1:0] vrow_t;

  row_t  key_mem [NUM_BUCKETS];
  vrow_t vld_mem [NUM_BUCKETS];

  state_e                     state_q;
  logic [BktW-1:0]            clr_cnt_q;
  logic [hsmt_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       out_vld_q, found_q, rej_q;
  hsmt_pkg::cmd_e             cmd_q;
  logic [hsmt_pkg::KEY_W-1:0] key_q;
  logic [BktW-1:0]            bkt_q;
  row_t                       key_rd_q, key_new;
  vrow_t                      vld_rd_q, vld_new;

  vrow_t           hit_vec, hit_oh, free_oh;
  logic            found, any_free, rej_d;
  logic            rd_en, commit, vld_we, key_we;
  logic            vld_wr;
  logic [BktW-1:0] vld_wa;
  vrow_t           vld_wd;

  assign clr_done_o  = (state_q != StClear);
  assign pop_ready_o = (state_q == StIdle);
  assign rd_en       = pop_valid_i && pop_ready_o;
  assign commit      = (state_q == StExec) && (!out_vld_q || out_o.ready);

  always_comb begin
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      hit_vec[s] = vld_rd_q[s] && (key_rd_q[s] == key_q);
    end
    found    = |hit_vec;
    any_free = ~&vld_rd_q;
    hit_oh   = hit_vec & (~hit_vec + vrow_t'(1));
    free_oh  = ~vld_rd_q & (vld_rd_q + vrow_t'(1));
  end

  always_comb begin
    vld_new = vld_rd_q;
    key_new = key_rd_q;
    cnt_d   = cnt_q;
    rej_d   = 1'b0;
    vld_we  = 1'b0;
    key_we  = 1'b0;
    unique case (cmd_q)
      hsmt_pkg::CmdInsert: begin
        if (!found) begin
          if (any_free) begin
            vld_new = vld_rd_q | free_oh;
            for (int s = 0; s < BUCKET_SLOTS; s++) begin
              if (free_oh[s]) key_new[s] = key_q;
            end
            cnt_d  = cnt_q + hsmt_pkg::CNT_W'(1);
            vld_we = 1'b1;
            key_we = 1'b1;
          end else begin
            rej_d = 1'b1;
          end
        end
      end
      hsmt_pkg::CmdRemove: begin
        if (found) begin
          vld_new = vld_rd_q & ~hit_oh;
          cnt_d   = cnt_q - hsmt_pkg::CNT_W'(1);
          vld_we  = 1'b1;
        end
      end
      default: begin
        // exists query and the unused code change nothing
      end
    endcase
  end

  // single write port of the valid store: clearing sweep or write back
  always_comb begin
    vld_wr = (state_q == StClear) || (commit && vld_we);
    vld_wa = (state_q == StClear) ? clr_cnt_q : bkt_q;
    vld_wd = (state_q == StClear) ? '0 : vld_new;
  end

  always_ff @(posedge clk_i) begin
    if (vld_wr) begin
      vld_mem[vld_wa] <= vld_wd;
    end
    if (rd_en) begin
      vld_rd_q <= vld_mem[pop_bucket_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && key_we) begin
      key_mem[bkt_q] <= key_new;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[pop_bucket_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cmd_q <= hsmt_pkg::cmd_e'(pop_cmd_i);
      key_q <= pop_key_i;
      bkt_q <= pop_bucket_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_cnt_q <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      found_q   <= 1'b0;
      rej_q     <= 1'b0;
    end else begin
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_cnt_q <= clr_cnt_q + BktW'(1);
          if (clr_cnt_q == BktW'(NUM_BUCKETS - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (rd_en) state_q <= StExec;
        end
        StExec: begin
          if (commit) begin
            found_q   <= found;
            rej_q     <= rej_d;
            cnt_q     <= cnt_d;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.found       = found_q;
  assign out_o.rejected    = rej_q;
  assign out_o.entry_count = cnt_q;

endmodule

`default_nettype wire

### rtl/hsmt_checker.sv
// Port-level checker for the hash set membership table, bound to the top level.
`default_nettype none

`include "hash_set_membership_table_top_macros.svh"

module hsmt_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_valid_i,
  input wire                       in_ready_i,
  input wire                       out_valid_i,
  input wire                       out_ready_i,
  input wire                       found_i,
  input wire                       rejected_i,
  input wire [hsmt_pkg::CNT_W-1:0] entry_count_i
);

  logic                       in_xfer, out_xfer;
  logic [7:0]                 pend_q;
  logic [hsmt_pkg::CNT_W-1:0] last_q, last_inc, last_dec;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;
  assign last_inc = last_q + hsmt_pkg::CNT_W'(1);
  assign last_dec = last_q - hsmt_pkg::CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      last_q <= '0;
    end else begin
      if (in_xfer && !out_xfer) begin
        pend_q <= pend_q + 8'd1;
      end else if (out_xfer && !in_xfer) begin
        pend_q <= pend_q - 8'd1;
      end
      if (out_xfer) begin
        last_q <= entry_count_i;
      end
    end
  end

  `HSMT_ASSERT_IMPL(a_no_phantom, clk_i, rst_ni, out_valid_i, pend_q != 8'd0, "result without command")
  `HSMT_ASSERT_ALWAYS(a_rej_excl, clk_i, rst_ni, !(out_xfer && rejected_i && (found_i || entry_count_i != last_q)), "rejected with hit or count change")
  `HSMT_ASSERT_IMPL(a_cnt_step, clk_i, rst_ni, out_xfer, entry_count_i == last_q || entry_count_i == last_inc || entry_count_i == last_dec, "count jumped")
  `HSMT_ASSERT_IMPL(a_grow_miss, clk_i, rst_ni, out_xfer && entry_count_i == last_inc, !found_i, "count grew on a hit")

endmodule

bind hash_set_membership_table_top hsmt_checker u_hsmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_i.valid),
  .in_ready_i    (cmd_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .found_i       (res_o.found),
  .rejected_i    (res_o.rejected),
  .entry_count_i (res_o.entry_count)
);

`default_nettype wire

### verif/tb_hash_set_membership_table_top.sv
// Self-checking testbench for the hash set membership table: directed table plus random traffic.
module tb_hash_set_membership_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsmt_pkg::*;

  localparam int unsigned NUM_BUCKETS  = 64;
  localparam int unsigned BUCKET_SLOTS = 4;
  localparam int unsigned TOTAL_SLOTS  = NUM_BUCKETS * BUCKET_SLOTS;
  localparam int unsigned RANDOM_ITEMS = 500;
  // Quiet-cycle limit: clearing pass + longest send gap + latency
  // + longest result stall, taken many times over.
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES  = 30;

  // Hash constants, full width, straight from the spec of the bucket mapping.
  localparam logic [63:0] MIX_MUL = 64'd2895701;
  localparam logic [63:0] MIX_ADD = 64'd78126498113;

  // The fourth command code is not in the package enum; it acts as exists.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic             found;
    logic             rejected;
    logic [CNT_W-1:0] entry_count;
  } outcome_t;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] key;
    bit               typed;   // want was typed in by hand
    outcome_t         want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  hsmt_in_if  cmd_if ();
  hsmt_out_if res_if ();

  hash_set_membership_table_top #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_SLOTS (BUCKET_SLOTS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // Mirror of the set contents, advanced at every command transfer.
  logic [KEY_W-1:0] mirror_key   [TOTAL_SLOTS];
  bit               mirror_valid [TOTAL_SLOTS];
  logic [CNT_W-1:0] mirror_count;

  outcome_t  pending_outcomes [$];
  stim_row_t directed_rows    [$];
  logic [KEY_W-1:0] key_pool  [$];

  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  bit          calm;   // stretch with no idling on either side

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // |low32(key*mul + add)| mod NUM_BUCKETS; the most negative hash maps as 2^31.
  function automatic int unsigned bucket_of_key(input logic [KEY_W-1:0] k);
    logic [63:0] mixed;
    logic [31:0] h;
    logic [31:0] mag;
    mixed = {32'd0, k} * MIX_MUL + MIX_ADD;
    h     = mixed[31:0];
    mag   = h[31] ? (~h + 32'd1) : h;
    return mag % NUM_BUCKETS;
  endfunction

  // Key whose hash is exactly h: invert the odd multiplier mod 2^32 (Newton).
  function automatic logic [KEY_W-1:0] key_for_hash(input logic [31:0] h);
    logic [31:0] mul;
    logic [31:0] inv;
    mul = MIX_MUL[31:0];
    inv = mul;
    repeat (5) inv = inv * (32'd2 - mul * inv);
    return (h - MIX_ADD[31:0]) * inv;
  endfunction

  // Apply one command to the mirror and return the result it must produce.
  function automatic outcome_t apply_command(input logic [CMD_W-1:0] op,
                                             input logic [KEY_W-1:0] k);
    int unsigned base;
    int          hit;
    int          free_slot;
    outcome_t    o;
    base      = bucket_of_key(k) * BUCKET_SLOTS;
    hit       = -1;
    free_slot = -1;
    o         = '0;
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      if (mirror_valid[base + s]) begin
        if (hit < 0 && mirror_key[base + s] == k) hit = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (op == CmdInsert) begin
      if (hit < 0) begin
        if (free_slot >= 0) begin
          mirror_key[base + free_slot]   = k;
          mirror_valid[base + free_slot] = 1'b1;
          mirror_count++;
        end else begin
          o.rejected = 1'b1;
        end
      end
    end else if (op == CmdRemove) begin
      if (hit >= 0) begin
        mirror_valid[base + hit] = 1'b0;
        mirror_count--;
      end
    end
    // exists and the unused code touch nothing
    o.found       = (hit >= 0);
    o.entry_count = mirror_count;
    return o;
  endfunction

  function automatic outcome_t outcome(input logic f, input logic r,
                                       input logic [CNT_W-1:0] c);
    outcome_t o;
    o.found       = f;
    o.rejected    = r;
    o.entry_count = c;
    return o;
  endfunction

  function automatic void add_row(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                                  input bit typed, input outcome_t want);
    stim_row_t row;
    row.op    = op;
    row.key   = k;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Idle length: mostly none or short, now and then long; none in a calm stretch.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  // Entered just after a falling edge; leaves just after the falling edge that
  // follows the transfer, so valid is never lowered and raised in one step.
  task automatic transfer_command(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] k,
                                  input bit typed, input outcome_t want);
    int unsigned gap;
    outcome_t    predicted;
    gap = idle_cycles();
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= op;
    cmd_if.key     <= k;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    // transfer happened at this edge: the mirror moves in command order
    predicted = apply_command(op, k);
    pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Result side backpressure: ready held in runs, stalls mostly short.
  initial begin : result_ready_drive
    int unsigned hold;
    res_if.ready = 1'b0;
    hold         = 0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (calm || $urandom_range(0, 99) < 60) begin
        res_if.ready <= 1'b1;
        hold = $urandom_range(0, 12);
      end else begin
        res_if.ready <= 1'b0;
        hold = idle_cycles();
      end
    end
  end

  // Result checker: every result transfer pairs with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected, actual found %0b rejected %0b count %0d",
                 $time, res_if.found, res_if.rejected, res_if.entry_count);
      end else begin
        want = pending_outcomes.pop_front();
        if (res_if.found !== want.found)
          report_mismatch("found", want.found, res_if.found);
        if (res_if.rejected !== want.rejected)
          report_mismatch("rejected", want.rejected, res_if.rejected);
        if (res_if.entry_count !== want.entry_count)
          report_mismatch("entry_count", want.entry_count, res_if.entry_count);
      end
    end
  end

  // Watchdog: too long with no transfer on either side ends the run.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("hash_set_membership_table_top regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] same_bucket [5];
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] neg_hash_key;
    logic [CMD_W-1:0] op;
    int unsigned      target;
    int unsigned      found_cnt;
    int unsigned      hot [6];
    int unsigned      roll;
    int unsigned      mode;   // 0 fill, 1 drain, 2 mixed

    cmd_if.valid   = 1'b0;
    cmd_if.command = CmdExists;
    cmd_if.key     = '0;
    rst_ni         = 1'b0;
    calm           = 1'b0;
    mirror_count   = '0;
    foreach (mirror_valid[i]) mirror_valid[i] = 1'b0;

    // Five keys sharing one bucket: four fill it, the fifth bounces.
    target    = bucket_of_key(32'd1000);
    found_cnt = 0;
    k         = 32'd1000;
    while (found_cnt < 5) begin
      if (bucket_of_key(k) == target) begin
        same_bucket[found_cnt] = k;
        found_cnt++;
      end
      k++;
    end
    neg_hash_key = key_for_hash(32'h8000_0000);

    // Directed table. Hand-typed results only where they are obvious.
    add_row(CmdExists, 32'h0000_0000, 1'b1, outcome(1'b0, 1'b0, 9'd0));  // empty after reset
    add_row(CmdInsert, 32'h8000_0000, 1'b1, outcome(1'b0, 1'b0, 9'd1));
    add_row(CmdInsert, 32'h7fff_ffff, 1'b1, outcome(1'b0, 1'b0, 9'd2));
    add_row(CmdInsert, 32'h8000_0000, 1'b1, outcome(1'b1, 1'b0, 9'd2));  // duplicate
    add_row(CmdExists, 32'h7fff_ffff, 1'b1, outcome(1'b1, 1'b0, 9'd2));
    add_row(CmdRemove, 32'h7fff_ffff, 1'b1, outcome(1'b1, 1'b0, 9'd1));
    add_row(CmdRemove, 32'h7fff_ffff, 1'b1, outcome(1'b0, 1'b0, 9'd1));  // absent
    add_row(CMD_UNUSED, 32'h8000_0000, 1'b1, outcome(1'b1, 1'b0, 9'd1));
    add_row(CMD_UNUSED, 32'hffff_ffff, 1'b1, outcome(1'b0, 1'b0, 9'd1));
    for (int i = 0; i < 5; i++) add_row(CmdInsert, same_bucket[i], 1'b0, '0);
    add_row(CmdRemove, same_bucket[1], 1'b0, '0);
    add_row(CmdInsert, same_bucket[4], 1'b0, '0);   // takes the freed lower slot
    add_row(CmdExists, same_bucket[4], 1'b0, '0);
    add_row(CmdRemove, same_bucket[0], 1'b0, '0);
    add_row(CmdInsert, neg_hash_key, 1'b0, '0);      // hash is exactly -2^31
    add_row(CmdExists, neg_hash_key, 1'b0, '0);
    add_row(CmdRemove, neg_hash_key, 1'b0, '0);
    add_row(CmdInsert, 32'hffff_ffff, 1'b0, '0);
    add_row(CmdRemove, 32'h8000_0000, 1'b0, '0);

    // Key pool: half crowded into a few hot buckets so they fill and reject.
    foreach (hot[i]) hot[i] = $urandom_range(0, NUM_BUCKETS - 1);
    for (int i = 0; i < 48; i++) begin
      do k = $urandom(); while (bucket_of_key(k) != hot[i % 6]);
      key_pool.insert(key_pool.size(), k);
    end
    for (int i = 0; i < 48; i++) key_pool.insert(key_pool.size(), $urandom());

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      transfer_command(directed_rows[i].op, directed_rows[i].key,
                       directed_rows[i].typed, directed_rows[i].want);

    mode = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        mode = $urandom_range(0, 2);
        calm = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (mode)
        0: op = (roll < 60) ? CmdInsert : (roll < 80) ? CmdExists :
                (roll < 95) ? CmdRemove : CMD_UNUSED;
        1: op = (roll < 20) ? CmdInsert : (roll < 40) ? CmdExists :
                (roll < 95) ? CmdRemove : CMD_UNUSED;
        default: op = (roll < 40) ? CmdInsert : (roll < 65) ? CmdExists :
                      (roll < 93) ? CmdRemove : CMD_UNUSED;
      endcase
      if ($urandom_range(0, 99) < 65)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else
        k = $urandom();
      transfer_command(op, k, 1'b0, '0);
    end
    cmd_if.valid <= 1'b0;
    calm = 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0)
      $display("hash_set_membership_table_top regression: pass");
    else
      $display("hash_set_membership_table_top regression: fail");
    $finish;
  end

endmodule
